### hw/rtl/upr_pkg.sv
package upr_pkg;

  // Width of the request offset field on the result channel.
  localparam int OFF_W = 12;
  // Largest offset the result field can carry.
  localparam int OFF_MAX = (1 << OFF_W) - 1;

  // Character codes used by the recognizer.
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_USCORE   = 8'h5F;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;

  // Scan phase of the recognizer.
  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_SLASH1,
    PH_SLASH2,
    PH_HOST,
    PH_DONE
  } phase_t;

  // ASCII letters and digits only; bytes above 127 are neither.
  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
           (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
  endfunction

  function automatic logic is_scheme_char(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_USCORE) || (c == CH_DASH) || is_alnum(c);
  endfunction

  function automatic logic is_host_char(input logic [7:0] c);
    return is_scheme_char(c) || (c == CH_COLON) || (c == CH_AT);
  endfunction

  function automatic logic is_slash(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

endpackage

### hw/rtl/url_prefix_recognizer.sv
// Channel   Handshake            Payload                  Direction
// input     in_valid/in_ready    ch[7:0]                  into block
// result    out_valid/out_ready  is_valid, request_offset out of block
//
// One character word is taken per cycle while the input is ready; a verdict,
// when the word decides one, is in the output register on the next cycle.
// The input is ready whenever the output register is empty or being read,
// so the block only stalls while a verdict waits at the output.
// Synchronous active-high reset returns the scanner to the scheme phase
// with position zero and empties the output register.
module url_prefix_recognizer #(
  parameter int MAX_LEN = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                ch,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      is_valid,
  output logic [upr_pkg::OFF_W-1:0] request_offset
);
  import upr_pkg::*;

  localparam int POS_MAX = (MAX_LEN - 1 < OFF_MAX) ? (MAX_LEN - 1) : OFF_MAX;
  localparam int PW = $clog2(POS_MAX + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(POS_MAX);

  phase_t        phase, phase_next;
  logic [1:0]    scheme_len, scheme_len_next;
  logic [PW-1:0] position, position_next;

  logic accept;
  logic do_verdict;
  logic verdict_ok;
  logic do_advance;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Next scan state and verdict for the character at the input.
  always_comb begin
    phase_next      = phase;
    scheme_len_next = scheme_len;
    position_next   = position;
    do_verdict      = 1'b0;
    verdict_ok      = 1'b0;
    do_advance      = 1'b0;

    case (phase)
      PH_SCHEME: begin
        if (ch != CH_NUL && is_scheme_char(ch)) begin
          if (scheme_len < 2'd2) begin
            scheme_len_next = scheme_len + 2'd1;
          end
          do_advance = 1'b1;
        end else if (scheme_len == 2'd2 && ch == CH_COLON) begin
          phase_next = PH_SLASH1;
          do_advance = 1'b1;
        end else begin
          do_verdict = 1'b1;
        end
      end
      PH_SLASH1: begin
        if (is_slash(ch)) begin
          phase_next = PH_SLASH2;
          do_advance = 1'b1;
        end else begin
          do_verdict = 1'b1;
        end
      end
      PH_SLASH2, PH_HOST: begin
        if (phase == PH_SLASH2 && is_slash(ch)) begin
          phase_next = PH_HOST;
          do_advance = 1'b1;
        end else if (ch != CH_NUL && is_host_char(ch)) begin
          phase_next = PH_HOST;
          do_advance = 1'b1;
        end else begin
          do_verdict = 1'b1;
          verdict_ok = (ch == CH_NUL) || is_slash(ch);
        end
      end
      default: begin
        // Done: drop characters until the terminating NUL.
        if (ch == CH_NUL) begin
          phase_next      = PH_SCHEME;
          scheme_len_next = 2'd0;
          position_next   = '0;
        end
      end
    endcase

    if (do_advance && position < POS_LAST) begin
      position_next = position + PW'(1);
    end

    // A verdict on NUL restarts the scan; any other one waits for NUL.
    if (do_verdict) begin
      if (ch == CH_NUL) begin
        phase_next      = PH_SCHEME;
        scheme_len_next = 2'd0;
        position_next   = '0;
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SCHEME;
      scheme_len <= 2'd0;
      position   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      scheme_len <= scheme_len_next;
      position   <= position_next;
    end
  end

  // Output register; it is always free or being emptied when a word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= do_verdict;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_verdict) begin
      is_valid       <= verdict_ok;
      request_offset <= verdict_ok ? OFF_W'(position) : '0;
    end
  end

  // A rejected string never reports an offset.
  a_reject_zero_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_valid |-> request_offset == '0)
    else $error("rejected verdict carries a nonzero offset");

  // A new verdict only appears after a word was taken.
  a_result_needs_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("verdict appeared without an accepted word");

  // A taken NUL always restarts the scan.
  a_nul_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && ch == CH_NUL |=> phase == PH_SCHEME && position == '0 &&
                               scheme_len == 2'd0)
    else $error("NUL did not restart the scan");

  // The offset never exceeds the saturation limit.
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> request_offset <= OFF_W'(POS_MAX))
    else $error("offset beyond saturation limit");

endmodule

### sim/url_prefix_recognizer_tb.sv
`timescale 1ns / 100ps

module url_prefix_recognizer_tb;
  import upr_pkg::*;

  localparam int MAX_LEN = 4096;
  localparam int POS_MAX = (MAX_LEN - 1 < OFF_MAX) ? MAX_LEN - 1 : OFF_MAX;
  localparam int CYCLE_LIMIT = 400000;

  // One verdict as it appears on the result channel.
  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] off;
  } verdict_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct packed {
    logic [7:0]       c;
    bit               typed;
    bit               has;
    logic             ok;
    logic [OFF_W-1:0] off;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       ch = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             is_valid;
  logic [OFF_W-1:0] request_offset;

  // Scanner state mirrored by the verdict predictor.
  phase_t           scan_ph = PH_SCHEME;
  logic [1:0]       scheme_cnt = 2'd0;
  logic [OFF_W-1:0] scan_pos = '0;

  verdict_t verdict_q [$];
  int       err_cnt = 0;
  int       items_sent = 0;
  int       cycle_cnt = 0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  int       hold_at = 32'h7fffffff;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  // Directed strings: empty, non-ASCII, short scheme, slash-phase NUL and valid urls.
  dir_row_t dir_tab [0:24] = '{
    '{CH_NUL,    1'b1, 1'b1, 1'b0, 12'd0},
    '{8'hFF,     1'b1, 1'b1, 1'b0, 12'd0},
    '{CH_NUL,    1'b1, 1'b0, 1'b0, 12'd0},
    '{"a",       1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_COLON,  1'b1, 1'b1, 1'b0, 12'd0},
    '{8'h80,     1'b1, 1'b0, 1'b0, 12'd0},
    '{CH_NUL,    1'b1, 1'b0, 1'b0, 12'd0},
    '{".",       1'b0, 1'b0, 1'b0, 12'd0},
    '{"-",       1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_COLON,  1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_NUL,    1'b1, 1'b1, 1'b0, 12'd0},
    '{"a",       1'b0, 1'b0, 1'b0, 12'd0},
    '{"b",       1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_COLON,  1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 12'd0},
    '{"x",       1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_NUL,    1'b0, 1'b0, 1'b0, 12'd0},
    '{"Z",       1'b0, 1'b0, 1'b0, 12'd0},
    '{"9",       1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_COLON,  1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_AT,     1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 12'd0},
    '{CH_NUL,    1'b0, 1'b0, 1'b0, 12'd0}
  };

  url_prefix_recognizer #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_valid      (is_valid),
    .request_offset(request_offset)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character classes of the url grammar.
  function automatic bit scheme_ch(input logic [7:0] c);
    return c == CH_DOT || c == CH_USCORE || c == CH_DASH ||
           (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
           (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
  endfunction

  function automatic bit host_ch(input logic [7:0] c);
    return scheme_ch(c) || c == CH_COLON || c == CH_AT;
  endfunction

  function automatic bit slash_ch(input logic [7:0] c);
    return c == CH_SLASH || c == CH_BSLASH;
  endfunction

  // Random characters drawn from each class.
  function automatic logic [7:0] pick_scheme();
    int r;
    r = $urandom_range(0, 64);
    if (r < 10) return CH_DIGIT_LO + 8'(r);
    if (r < 36) return CH_UPPER_LO + 8'(r - 10);
    if (r < 62) return CH_LOWER_LO + 8'(r - 36);
    if (r == 62) return CH_DOT;
    if (r == 63) return CH_USCORE;
    return CH_DASH;
  endfunction

  function automatic logic [7:0] pick_host();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CH_COLON;
    if (r == 1) return CH_AT;
    return pick_scheme();
  endfunction

  function automatic logic [7:0] pick_bad();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (host_ch(c) || slash_ch(c));
    return c;
  endfunction

  // Advances the mirrored scanner by one character and reports any verdict.
  task automatic predict_verdict(input logic [7:0] c, output bit fire, output verdict_t v);
    bit ok;
    bit adv;
    bit restart_now;
    fire = 1'b0;
    ok = 1'b0;
    adv = 1'b0;
    restart_now = 1'b0;
    v = '0;
    case (scan_ph)
      PH_SCHEME: begin
        if (c != CH_NUL && scheme_ch(c)) begin
          if (scheme_cnt < 2'd2) scheme_cnt++;
          adv = 1'b1;
        end else if (scheme_cnt == 2'd2 && c == CH_COLON) begin
          scan_ph = PH_SLASH1;
          adv = 1'b1;
        end else begin
          fire = 1'b1;
        end
      end
      PH_SLASH1: begin
        if (slash_ch(c)) begin
          scan_ph = PH_SLASH2;
          adv = 1'b1;
        end else begin
          fire = 1'b1;
        end
      end
      PH_SLASH2, PH_HOST: begin
        if ((scan_ph == PH_SLASH2 && slash_ch(c)) || (c != CH_NUL && host_ch(c))) begin
          scan_ph = PH_HOST;
          adv = 1'b1;
        end else begin
          // The host ends well only on NUL or a slash.
          fire = 1'b1;
          ok = (c == CH_NUL) || slash_ch(c);
        end
      end
      default: begin
        // Trailing characters are dropped until NUL.
        restart_now = (c == CH_NUL);
      end
    endcase
    if (adv && scan_pos < POS_MAX) scan_pos++;
    if (fire) begin
      v.ok = ok;
      v.off = ok ? scan_pos : '0;
      if (c == CH_NUL) restart_now = 1'b1;
      else scan_ph = PH_DONE;
    end
    if (restart_now) begin
      scan_ph = PH_SCHEME;
      scheme_cnt = 2'd0;
      scan_pos = '0;
    end
  endtask

  // Offers one character word, with random idle cycles in front of it.
  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input bit t_has = 1'b0, input verdict_t t_v = '0);
    bit       fire;
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      ch <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(c, fire, v);
    if (typed) begin
      fire = t_has;
      v = t_v;
    end
    if (fire) verdict_q.push_back(v);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends one random string: mostly well-formed urls, some broken ones and noise.
  task automatic send_string();
    logic [7:0] s [$];
    int         kind;
    int         term;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(0, 1)) s.push_back(pick_scheme());
      end else begin
        repeat ($urandom_range(2, 5)) s.push_back(pick_scheme());
      end
      s.push_back(CH_COLON);
      repeat ($urandom_range(1, 2)) s.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
      repeat ($urandom_range(0, 10)) s.push_back(pick_host());
      term = $urandom_range(0, 3);
      if (term != 0) begin
        s.push_back(term == 1 ? CH_SLASH : term == 2 ? CH_BSLASH : pick_bad());
        repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
      end
      s.push_back(CH_NUL);
      // A broken url has one character replaced by a random byte.
      if (kind >= 60) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 12)) s.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 7) s.push_back(CH_NUL);
    end
    foreach (s[i]) send_char(s[i]);
  endtask

  // Stops offering and waits until every expected verdict has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n);
    int stop_at;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_string();
    wait_drained();
  endtask

  // Result side ready, with random stalls and one long hold-off.
  always @(negedge clk) begin
    if (!rst && !hold_done && items_sent >= hold_at) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compare each accepted verdict with the oldest expected one.
  always @(posedge clk) begin : check_verdict
    verdict_t exp_v;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected verdict, is_valid %0b, request_offset %0d",
                 $time, is_valid, request_offset);
      end else begin
        exp_v = verdict_q.pop_front();
        if (is_valid !== exp_v.ok) begin
          err_cnt++;
          $display("%0t: is_valid expected %0b, got %0b", $time, exp_v.ok, is_valid);
        end
        if (request_offset !== exp_v.off) begin
          err_cnt++;
          $display("%0t: request_offset expected %0d, got %0d",
                   $time, exp_v.off, request_offset);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main stimulus sequence.
  initial begin
    dir_row_t r;
    verdict_t tv;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed strings, no idling.
    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      tv.ok = r.ok;
      tv.off = r.off;
      send_char(r.c, r.typed, r.has, tv);
    end
    wait_drained();

    // Random strings under each idling pattern; the hold-off lands in the first.
    hold_at = items_sent + 200;
    run_phase(0, 0, 500);
    run_phase(48, 0, 480);
    run_phase(0, 48, 480);
    run_phase(11, 11, 480);

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
